// File: design/rpo_pkg.sv
// Shared types, constants and helpers for the RGB pixel point-operation pipeline.
`default_nettype none
package rpo_pkg;

	typedef enum logic [3:0] {
		MODE_ADD    = 4'd0,
		MODE_SUB    = 4'd1,
		MODE_SCALE  = 4'd2,
		MODE_DIV    = 4'd3,
		MODE_GRAY_R = 4'd4,
		MODE_GRAY_G = 4'd5,
		MODE_GRAY_B = 4'd6,
		MODE_LUMA   = 4'd7,
		MODE_SEPIA  = 4'd8,
		MODE_ORANGE = 4'd9
	} mode_t;

	localparam logic [3:0] CFG_MODE      = 4'd0;
	localparam logic [3:0] CFG_MAX_VALUE = 4'd1;
	localparam logic [3:0] CFG_SCALE     = 4'd2;
	localparam logic [3:0] CFG_DIVISOR   = 4'd3;

	localparam logic [7:0]  MAX_VALUE_RST = 8'd1;
	localparam logic [15:0] SCALE_RST     = 16'd256;
	localparam logic [15:0] DIVISOR_RST   = 16'd256;

	// numerator and remainder width: worst case is scale mode, 255 * 32767
	localparam int NUM_W  = 25;
	localparam int COEF_W = 15;
	localparam int PROD_W = 23;

	localparam logic [COEF_W-1:0] LUMA_K [3] = '{15'd2126, 15'd7152, 15'd722};
	localparam logic [COEF_W-1:0] SEPIA_K [3][3] = '{
		'{15'd393, 15'd769, 15'd189},
		'{15'd349, 15'd686, 15'd168},
		'{15'd272, 15'd534, 15'd131}
	};
	localparam logic [COEF_W-1:0] ORANGE_K [3][3] = '{
		'{15'd4, 15'd2, 15'd0},
		'{15'd4, 15'd2, 15'd0},
		'{15'd0, 15'd0, 15'd1}
	};
	localparam logic [15:0] ORANGE_DEN [3] = '{16'd3, 16'd6, 16'd2};

	localparam logic [15:0] DEN_ONE   = 16'd1;
	localparam logic [15:0] DEN_Q8    = 16'd256;
	localparam logic [15:0] DEN_LUMA  = 16'd10000;
	localparam logic [15:0] DEN_SEPIA = 16'd1000;

	// one channel in flight through the restoring divider
	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [15:0]      den;
		logic [7:0]       quo;
		logic             ovf;
	} chan_t;

	// one restoring step: try to take den << k out of the remainder
	function automatic chan_t div_step(chan_t c, logic [2:0] k);
		chan_t            r;
		logic [NUM_W-1:0] dsh;
		r   = c;
		dsh = {{(NUM_W-16){1'b0}}, c.den} << k;
		if (c.rem >= dsh) begin
			r.rem    = c.rem - dsh;
			r.quo[k] = 1'b1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: design/rgb_pixel_point_ops.sv
// Throughput: one pixel per cycle unless m_axis_tready holds the output back; seven
// stages: multiply, sum, then five stages of the eight-step restoring divider (one
// quotient bit in the first and last, two in between).
// Each stage advances on its own, so bubbles close up while the output stalls.
// Reset: mode add, max_value 1, scale 1.0, divisor 1.0; pipeline empties.
`default_nettype none
module rgb_pixel_point_ops (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// a_red, a_green, a_blue, b_red, b_green, b_blue from bit 0 up
	input  wire logic [47:0] s_axis_tdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// out_red, out_green, out_blue from bit 0 up
	output logic [23:0]      m_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int NW = rpo_pkg::NUM_W;
	localparam int CW = rpo_pkg::COEF_W;
	localparam int PW = rpo_pkg::PROD_W;

	// configuration registers
	rpo_pkg::mode_t mode_q;
	logic [7:0]     max_q;
	logic [15:0]    scale_q;
	logic [15:0]    div_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= rpo_pkg::MODE_ADD;
			max_q   <= rpo_pkg::MAX_VALUE_RST;
			scale_q <= rpo_pkg::SCALE_RST;
			div_q   <= rpo_pkg::DIVISOR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rpo_pkg::CFG_MODE: mode_q <= rpo_pkg::mode_t'(cfg_data[3:0]);
				rpo_pkg::CFG_MAX_VALUE: begin
					// zero is not a legal limit; keep the old one
					if (cfg_data[7:0] != 8'd0)
						max_q <= cfg_data[7:0];
				end
				rpo_pkg::CFG_SCALE:   scale_q <= cfg_data;
				rpo_pkg::CFG_DIVISOR: div_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage handshake
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic [7:1] adv;

	assign adv[7] = !vld_s7 || m_axis_tready;
	assign adv[6] = !vld_s6 || adv[7];
	assign adv[5] = !vld_s5 || adv[6];
	assign adv[4] = !vld_s4 || adv[5];
	assign adv[3] = !vld_s3 || adv[4];
	assign adv[2] = !vld_s2 || adv[3];
	assign adv[1] = !vld_s1 || adv[2];

	assign s_axis_tready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (adv[1]) vld_s1 <= s_axis_tvalid;
			if (adv[2]) vld_s2 <= vld_s1;
			if (adv[3]) vld_s3 <= vld_s2;
			if (adv[4]) vld_s4 <= vld_s3;
			if (adv[5]) vld_s5 <= vld_s4;
			if (adv[6]) vld_s6 <= vld_s5;
			if (adv[7]) vld_s7 <= vld_s6;
		end
	end

	// stage 1: every mode becomes sum(coef * a) + extra over a denominator
	logic [2:0][7:0]          pix_a, pix_b;
	logic [2:0][2:0][CW-1:0]  coef;
	logic [2:0][8:0]          extra;
	logic [2:0][15:0]         den;
	logic                     zdiv;
	logic                     sf_pos;

	assign pix_a  = s_axis_tdata[23:0];
	assign pix_b  = s_axis_tdata[47:24];
	assign sf_pos = !scale_q[15] && (scale_q != 16'd0);

	always_comb begin
		coef  = '0;
		extra = '0;
		den   = {3{rpo_pkg::DEN_ONE}};
		zdiv  = 1'b0;
		unique case (mode_q)
			rpo_pkg::MODE_ADD: begin
				for (int c = 0; c < 3; c++)
					extra[c] = {1'b0, pix_a[c]} + {1'b0, pix_b[c]};
			end
			rpo_pkg::MODE_SUB: begin
				for (int c = 0; c < 3; c++)
					extra[c] = (pix_a[c] > pix_b[c]) ? {1'b0, pix_a[c] - pix_b[c]} : 9'd0;
			end
			rpo_pkg::MODE_SCALE: begin
				// negative or zero factor leaves the coefficients at zero
				for (int c = 0; c < 3; c++) begin
					if (sf_pos)
						coef[c][c] = scale_q[CW-1:0];
					den[c] = rpo_pkg::DEN_Q8;
				end
			end
			rpo_pkg::MODE_DIV: begin
				for (int c = 0; c < 3; c++) begin
					coef[c][c] = CW'(rpo_pkg::DEN_Q8);
					den[c]     = div_q;
				end
				zdiv = (div_q == 16'd0);
			end
			rpo_pkg::MODE_GRAY_R: begin
				for (int c = 0; c < 3; c++)
					coef[c][0] = CW'(1);
			end
			rpo_pkg::MODE_GRAY_G: begin
				for (int c = 0; c < 3; c++)
					coef[c][1] = CW'(1);
			end
			rpo_pkg::MODE_GRAY_B: begin
				for (int c = 0; c < 3; c++)
					coef[c][2] = CW'(1);
			end
			rpo_pkg::MODE_LUMA: begin
				for (int c = 0; c < 3; c++) begin
					for (int j = 0; j < 3; j++)
						coef[c][j] = rpo_pkg::LUMA_K[j];
					den[c] = rpo_pkg::DEN_LUMA;
				end
			end
			rpo_pkg::MODE_SEPIA: begin
				for (int c = 0; c < 3; c++) begin
					for (int j = 0; j < 3; j++)
						coef[c][j] = rpo_pkg::SEPIA_K[c][j];
					den[c] = rpo_pkg::DEN_SEPIA;
				end
			end
			rpo_pkg::MODE_ORANGE: begin
				for (int c = 0; c < 3; c++) begin
					for (int j = 0; j < 3; j++)
						coef[c][j] = rpo_pkg::ORANGE_K[c][j];
					den[c] = rpo_pkg::ORANGE_DEN[c];
				end
			end
			default: ;
		endcase
	end

	logic [2:0][2:0][PW-1:0] prod_s1;
	logic [2:0][8:0]         extra_s1;
	logic [2:0][15:0]        den_s1;
	logic                    zdiv_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int c = 0; c < 3; c++)
				for (int j = 0; j < 3; j++)
					prod_s1[c][j] <= PW'(pix_a[j]) * PW'(coef[c][j]);
			extra_s1 <= extra;
			den_s1   <= den;
			zdiv_s1  <= zdiv;
		end
	end

	// stage 2: numerator sum
	logic [2:0][NW-1:0] num_s2;
	logic [2:0][15:0]   den_s2;
	logic               zdiv_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int c = 0; c < 3; c++)
				num_s2[c] <= NW'(prod_s1[c][0]) + NW'(prod_s1[c][1])
					+ NW'(prod_s1[c][2]) + NW'(extra_s1[c]);
			den_s2  <= den_s1;
			zdiv_s2 <= zdiv_s1;
		end
	end

	// stage 3: overflow check (quotient would pass 255) and quotient bit 7
	rpo_pkg::chan_t [2:0] ent, st3;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			ent[c].rem = num_s2[c];
			ent[c].den = den_s2[c];
			ent[c].quo = '0;
			ent[c].ovf = zdiv_s2
				|| (num_s2[c] >= ({{(NW-16){1'b0}}, den_s2[c]} << 8));
			st3[c] = rpo_pkg::div_step(ent[c], 3'd7);
		end
	end

	rpo_pkg::chan_t [2:0] ch_s3, ch_s4, ch_s5, ch_s6;

	always_ff @(posedge clk) begin
		if (adv[3]) ch_s3 <= st3;
		if (adv[4]) begin
			for (int c = 0; c < 3; c++)
				ch_s4[c] <= rpo_pkg::div_step(rpo_pkg::div_step(ch_s3[c], 3'd6), 3'd5);
		end
		if (adv[5]) begin
			for (int c = 0; c < 3; c++)
				ch_s5[c] <= rpo_pkg::div_step(rpo_pkg::div_step(ch_s4[c], 3'd4), 3'd3);
		end
		if (adv[6]) begin
			for (int c = 0; c < 3; c++)
				ch_s6[c] <= rpo_pkg::div_step(rpo_pkg::div_step(ch_s5[c], 3'd2), 3'd1);
		end
	end

	// stage 7: last quotient bit, clamp, output register
	rpo_pkg::chan_t [2:0] fin;
	logic [2:0][7:0]      res;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			fin[c] = rpo_pkg::div_step(ch_s6[c], 3'd0);
			if (fin[c].ovf || (fin[c].quo > max_q))
				res[c] = max_q;
			else
				res[c] = fin[c].quo;
		end
	end

	logic [2:0][7:0] pix_s7;

	always_ff @(posedge clk) begin
		if (adv[7]) pix_s7 <= res;
	end

	assign m_axis_tdata  = pix_s7;
	assign m_axis_tvalid = vld_s7;

endmodule
`default_nettype wire
